>>> hw/rtl/safp_pkg.sv
package safp_pkg;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic [7:0] pos;
  } safp_item_t;

  // Byte positions within the service data.
  localparam logic [7:0] POS_ADDR_FIRST = 8'd5;
  localparam logic [7:0] POS_ADDR_LAST  = 8'd10;
  localparam logic [7:0] POS_TYPE       = 8'd12;
  localparam logic [7:0] POS_VAL_FIRST  = 8'd15;
  localparam logic [7:0] POS_VAL_LAST   = 8'd18;
  localparam logic [7:0] POS_MAX        = 8'd255;

  // Measurement type codes carried at the type position.
  localparam logic [7:0] TYPE_TEMP     = 8'd4;
  localparam logic [7:0] TYPE_HUMID    = 8'd6;
  localparam logic [7:0] TYPE_LIGHT    = 8'd7;
  localparam logic [7:0] TYPE_MOIST    = 8'd8;
  localparam logic [7:0] TYPE_COND     = 8'd9;
  localparam logic [7:0] TYPE_BATT     = 8'd10;
  localparam logic [7:0] TYPE_TEMP_HUM = 8'd13;
  localparam logic [7:0] TYPE_FORMALD  = 8'd16;

  // Reported measurement kinds.
  localparam logic [3:0] KIND_NONE     = 4'd0;
  localparam logic [3:0] KIND_TEMP     = 4'd1;
  localparam logic [3:0] KIND_HUMID    = 4'd2;
  localparam logic [3:0] KIND_LIGHT    = 4'd3;
  localparam logic [3:0] KIND_MOIST    = 4'd4;
  localparam logic [3:0] KIND_COND     = 4'd5;
  localparam logic [3:0] KIND_BATT     = 4'd6;
  localparam logic [3:0] KIND_TEMP_HUM = 4'd7;
  localparam logic [3:0] KIND_FORMALD  = 4'd8;

  // Unknown codes held by the stores after reset.
  localparam logic signed [15:0] TEMP_UNKNOWN    = -16'sd990;
  localparam logic signed [15:0] HUMID_UNKNOWN   = -16'sd990;
  localparam logic signed [18:0] LIGHT_UNKNOWN   = -19'sd99;
  localparam logic signed [7:0]  MOIST_UNKNOWN   = -8'sd99;
  localparam logic signed [15:0] COND_UNKNOWN    = -16'sd99;
  localparam logic signed [7:0]  BATT_UNKNOWN    = -8'sd99;
  localparam logic signed [10:0] FORMALD_UNKNOWN = -11'sd990;

  // Plausibility limits.
  localparam logic signed [15:0] TEMP_LO      = -16'sd300;
  localparam logic signed [15:0] TEMP_HI      = 16'sd1000;
  localparam logic signed [15:0] HUMID_HI     = 16'sd1000;
  localparam logic        [23:0] LIGHT_LIMIT  = 24'd150000;
  localparam logic signed [15:0] MOIST_HI     = 16'sd100;
  localparam logic signed [15:0] COND_LIMIT   = 16'sd20000;
  localparam logic signed [15:0] FORMALD_HI   = 16'sd1000;

endpackage

>>> hw/rtl/safp_in_stage.sv
module safp_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_frame_byte,
  input  logic               in_final_byte,
  output logic               item_valid,
  output safp_pkg::safp_item_t item,
  input  logic               item_take
);
  import safp_pkg::*;

  logic                 vld_r;
  safp_item_t           item_r;
  logic [7:0]           pos_r;
  logic [7:0]           pos_nxt;
  logic                 acc;

  assign in_ready   = !vld_r || item_take;
  assign acc        = in_valid && in_ready;
  assign item_valid = vld_r;
  assign item       = item_r;

  always_comb begin
    pos_nxt = pos_r;
    if (acc) begin
      if (in_final_byte) begin
        pos_nxt = '0;
      end else if (pos_r != POS_MAX) begin
        pos_nxt = pos_r + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
      if (acc) begin
        vld_r <= 1'b1;
      end else if (item_take) begin
        vld_r <= 1'b0;
      end
    end
    if (acc) begin
      item_r.data <= in_frame_byte;
      item_r.last <= in_final_byte;
      item_r.pos  <= pos_r;
    end
  end

`ifndef NO_ASSERTIONS
  a_pos_restart: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_final_byte |=> pos_r == '0)
    else $error("byte position not cleared after a final word");
`endif

endmodule

>>> hw/rtl/safp_decode.sv
module safp_decode (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 item_valid,
  input  safp_pkg::safp_item_t item,
  output logic                 item_take,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [47:0]          out_device_address,
  output logic [3:0]           out_measure_kind,
  output logic                 out_value_changed,
  output logic                 out_plant_ready,
  output logic signed [15:0]   out_temperature_tenths,
  output logic signed [15:0]   out_humidity_tenths,
  output logic signed [18:0]   out_light_lux,
  output logic signed [7:0]    out_moisture_pct,
  output logic signed [15:0]   out_conductivity,
  output logic signed [7:0]    out_battery_level,
  output logic signed [10:0]   out_formaldehyde_tenths
);
  import safp_pkg::*;

  logic               out_valid_r;
  logic [47:0]        addr_r, addr_nxt;
  logic               known_r, known_nxt;
  logic [7:0]         type_r, type_nxt;
  logic [31:0]        val_r, val_nxt;
  logic signed [15:0] temp_r, temp_nxt;
  logic signed [15:0] humid_r, humid_nxt;
  logic signed [18:0] light_r, light_nxt;
  logic signed [7:0]  moist_r, moist_nxt;
  logic signed [15:0] cond_r, cond_nxt;
  logic signed [7:0]  batt_r, batt_nxt;
  logic signed [10:0] form_r, form_nxt;
  logic [3:0]         kind_nxt;
  logic               changed_nxt;
  logic               ready_nxt;
  logic [7:0]         addr_off, val_off;
  logic signed [15:0] lo, hi;
  logic [23:0]        v24;
  logic               len16, len17, len18, len19;

  assign item_take = item_valid && (!item.last || !out_valid_r || out_ready);
  assign out_valid = out_valid_r;

  assign addr_off = item.pos - POS_ADDR_FIRST;
  assign val_off  = item.pos - POS_VAL_FIRST;

  // Frame length is the final byte's position plus one.
  assign len16 = item.pos >= 8'd15;
  assign len17 = item.pos >= 8'd16;
  assign len18 = item.pos >= 8'd17;
  assign len19 = item.pos >= 8'd18;

  assign lo  = val_nxt[15:0];
  assign hi  = val_nxt[31:16];
  assign v24 = val_nxt[23:0];

  always_comb begin
    addr_nxt = addr_r;
    type_nxt = type_r;
    val_nxt  = val_r;
    if (item.pos >= POS_ADDR_FIRST && item.pos <= POS_ADDR_LAST && !known_r) begin
      addr_nxt[{addr_off[2:0], 3'b000} +: 8] = item.data;
    end
    if (item.pos == POS_TYPE) begin
      type_nxt = item.data;
    end
    if (item.pos >= POS_VAL_FIRST && item.pos <= POS_VAL_LAST) begin
      val_nxt[{val_off[1:0], 3'b000} +: 8] = item.data;
    end
  end

  always_comb begin
    known_nxt = known_r;
    temp_nxt  = temp_r;
    humid_nxt = humid_r;
    light_nxt = light_r;
    moist_nxt = moist_r;
    cond_nxt  = cond_r;
    batt_nxt  = batt_r;
    form_nxt  = form_r;
    kind_nxt  = KIND_NONE;
    if (item.last) begin
      if (item.pos >= 8'd11) begin
        known_nxt = 1'b1;
      end
      if (len16) begin
        case (type_nxt)
          TYPE_TEMP: begin
            if (len17) begin
              kind_nxt = KIND_TEMP;
              if (lo > TEMP_LO && lo < TEMP_HI) begin
                temp_nxt = lo;
              end
            end
          end
          TYPE_HUMID: begin
            if (len17) begin
              kind_nxt = KIND_HUMID;
              if (lo >= 16'sd0 && lo <= HUMID_HI) begin
                humid_nxt = lo;
              end
            end
          end
          TYPE_LIGHT: begin
            if (len18) begin
              kind_nxt = KIND_LIGHT;
              if (v24 < LIGHT_LIMIT) begin
                light_nxt = signed'(v24[18:0]);
              end
            end
          end
          TYPE_MOIST: begin
            if (len17) begin
              kind_nxt = KIND_MOIST;
              if (lo >= 16'sd0 && lo <= MOIST_HI) begin
                moist_nxt = lo[7:0];
              end
            end
          end
          TYPE_COND: begin
            if (len17) begin
              kind_nxt = KIND_COND;
              if (lo >= 16'sd0 && lo < COND_LIMIT) begin
                cond_nxt = lo;
              end
            end
          end
          TYPE_BATT: begin
            kind_nxt = KIND_BATT;
            batt_nxt = val_nxt[7:0];
          end
          TYPE_TEMP_HUM: begin
            if (len19) begin
              kind_nxt  = KIND_TEMP_HUM;
              temp_nxt  = lo;
              humid_nxt = hi;
            end
          end
          TYPE_FORMALD: begin
            if (len17) begin
              kind_nxt = KIND_FORMALD;
              if (lo >= 16'sd0 && lo <= FORMALD_HI) begin
                form_nxt = lo[10:0];
              end
            end
          end
          default: begin
            kind_nxt = KIND_NONE;
          end
        endcase
      end
    end
  end

  assign changed_nxt = (temp_nxt != temp_r) || (humid_nxt != humid_r) ||
                       (light_nxt != light_r) || (moist_nxt != moist_r) ||
                       (cond_nxt != cond_r) || (batt_nxt != batt_r) ||
                       (form_nxt != form_r);

  assign ready_nxt = (moist_nxt > MOIST_UNKNOWN) && (cond_nxt > COND_UNKNOWN) &&
                     (temp_nxt > TEMP_UNKNOWN) && (light_nxt > LIGHT_UNKNOWN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      addr_r      <= '0;
      known_r     <= 1'b0;
      type_r      <= '0;
      val_r       <= '0;
      temp_r      <= TEMP_UNKNOWN;
      humid_r     <= HUMID_UNKNOWN;
      light_r     <= LIGHT_UNKNOWN;
      moist_r     <= MOIST_UNKNOWN;
      cond_r      <= COND_UNKNOWN;
      batt_r      <= BATT_UNKNOWN;
      form_r      <= FORMALD_UNKNOWN;
    end else begin
      if (item_take && item.last) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (item_take) begin
        addr_r  <= addr_nxt;
        known_r <= known_nxt;
        type_r  <= type_nxt;
        val_r   <= val_nxt;
        temp_r  <= temp_nxt;
        humid_r <= humid_nxt;
        light_r <= light_nxt;
        moist_r <= moist_nxt;
        cond_r  <= cond_nxt;
        batt_r  <= batt_nxt;
        form_r  <= form_nxt;
      end
    end
    if (item_take && item.last) begin
      out_device_address      <= known_nxt ? addr_nxt : '0;
      out_measure_kind        <= kind_nxt;
      out_value_changed       <= changed_nxt;
      out_plant_ready         <= ready_nxt;
      out_temperature_tenths  <= temp_nxt;
      out_humidity_tenths     <= humid_nxt;
      out_light_lux           <= light_nxt;
      out_moisture_pct        <= moist_nxt;
      out_conductivity        <= cond_nxt;
      out_battery_level       <= batt_nxt;
      out_formaldehyde_tenths <= form_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_result_follows_final: assert property (@(posedge clk) disable iff (!rst_n)
    item_take && item.last |=> out_valid_r)
    else $error("final word did not produce a result");
  a_address_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    known_r |=> known_r && $stable(addr_r))
    else $error("captured address changed after it became known");
  a_moist_range: assert property (@(posedge clk) disable iff (!rst_n)
    moist_r == MOIST_UNKNOWN || (moist_r >= 8'sd0 && moist_r <= 8'sd100))
    else $error("soil moisture store out of range");
  a_no_kind_no_change: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_measure_kind == KIND_NONE |-> !out_value_changed)
    else $error("value changed without a decoded measurement");
`endif

endmodule

>>> hw/rtl/sensor_advert_frame_parser.sv
// Parses beacon advertisement service data arriving one word per cycle, the last word of
// each frame flagged by in_final_byte. Words are accepted back to back at one word per
// clock; the only stall comes from the result register, when a final word arrives while
// the previous frame's result is still waiting to be taken. Each final word yields exactly
// one result, registered first in the input stage and then in the result register,
// carrying the captured device address (zero until a frame of twelve or more words has
// been seen, and then fixed), the decoded measurement kind, a changed flag, the plant
// readiness flag and all stored sensor values, with unknown values held at their negative
// sentinel codes.
module sensor_advert_frame_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_frame_byte,
  input  logic               in_final_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [47:0]        out_device_address,
  output logic [3:0]         out_measure_kind,
  output logic               out_value_changed,
  output logic               out_plant_ready,
  output logic signed [15:0] out_temperature_tenths,
  output logic signed [15:0] out_humidity_tenths,
  output logic signed [18:0] out_light_lux,
  output logic signed [7:0]  out_moisture_pct,
  output logic signed [15:0] out_conductivity,
  output logic signed [7:0]  out_battery_level,
  output logic signed [10:0] out_formaldehyde_tenths
);
  import safp_pkg::*;

  logic       item_valid;
  logic       item_take;
  safp_item_t item;

  safp_in_stage u_in (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_frame_byte(in_frame_byte),
    .in_final_byte(in_final_byte),
    .item_valid   (item_valid),
    .item         (item),
    .item_take    (item_take)
  );

  safp_decode u_dec (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .item_valid             (item_valid),
    .item                   (item),
    .item_take              (item_take),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_device_address     (out_device_address),
    .out_measure_kind       (out_measure_kind),
    .out_value_changed      (out_value_changed),
    .out_plant_ready        (out_plant_ready),
    .out_temperature_tenths (out_temperature_tenths),
    .out_humidity_tenths    (out_humidity_tenths),
    .out_light_lux          (out_light_lux),
    .out_moisture_pct       (out_moisture_pct),
    .out_conductivity       (out_conductivity),
    .out_battery_level      (out_battery_level),
    .out_formaldehyde_tenths(out_formaldehyde_tenths)
  );

endmodule

>>> test/tb_top.sv
module tb_top;
  import safp_pkg::*;

  localparam int RANDOM_BYTES = 1160;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_CYCLES  = 400;
  localparam int NO_TYPED     = -1;

  typedef struct packed {
    logic [47:0]        addr;
    logic [3:0]         kind;
    logic               chg;
    logic               rdy;
    logic signed [15:0] temp;
    logic signed [15:0] hum;
    logic signed [18:0] lux;
    logic signed [7:0]  moist;
    logic signed [15:0] cond;
    logic signed [7:0]  batt;
    logic signed [10:0] form;
  } advert_result_t;

  typedef struct packed {
    int         len;
    logic [7:0] code;
    int         val;
    int         want_kind;
    int         want_chg;
  } frame_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] in_frame_byte = 8'h00;
  logic in_final_byte = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [47:0] out_device_address;
  logic [3:0] out_measure_kind;
  logic out_value_changed;
  logic out_plant_ready;
  logic signed [15:0] out_temperature_tenths;
  logic signed [15:0] out_humidity_tenths;
  logic signed [18:0] out_light_lux;
  logic signed [7:0] out_moisture_pct;
  logic signed [15:0] out_conductivity;
  logic signed [7:0] out_battery_level;
  logic signed [10:0] out_formaldehyde_tenths;

  int errors = 0;
  int cycle_count = 0;
  int sender_pace = 0;
  int receiver_pace = 0;
  advert_result_t pending_adverts[$];

  // Parser state mirrored on the testbench side, at its reset values.
  int pos_q = 0;
  logic [47:0] addr_q = '0;
  bit addr_known = 1'b0;
  logic [7:0] type_q = '0;
  logic [31:0] val_q = '0;
  int temp_st = -990;
  int hum_st = -990;
  int lux_st = -99;
  int moist_st = -99;
  int cond_st = -99;
  int batt_st = -99;
  int form_st = -990;

  frame_row_t directed_frames [0:24] = '{
    '{1,   8'h00,         0,            KIND_NONE,     0},
    '{11,  TYPE_TEMP,     0,            KIND_NONE,     0},
    '{12,  TYPE_TEMP,     0,            KIND_NONE,     0},
    '{15,  TYPE_TEMP,     0,            KIND_NONE,     0},
    '{16,  TYPE_BATT,     32'h80,       KIND_BATT,     1},
    '{16,  TYPE_TEMP,     0,            KIND_NONE,     0},
    '{17,  TYPE_TEMP,     999,          KIND_TEMP,     1},
    '{17,  TYPE_TEMP,     -299,         KIND_TEMP,     1},
    '{17,  TYPE_TEMP,     -300,         KIND_TEMP,     0},
    '{17,  TYPE_HUMID,    1000,         KIND_HUMID,    1},
    '{17,  TYPE_HUMID,    1001,         KIND_HUMID,    0},
    '{17,  TYPE_LIGHT,    0,            KIND_NONE,     0},
    '{18,  TYPE_LIGHT,    149999,       KIND_LIGHT,    1},
    '{18,  TYPE_LIGHT,    150000,       KIND_LIGHT,    0},
    '{17,  TYPE_MOIST,    100,          KIND_MOIST,    1},
    '{17,  TYPE_MOIST,    101,          KIND_MOIST,    0},
    '{17,  TYPE_COND,     19999,        KIND_COND,     1},
    '{17,  TYPE_COND,     20000,        KIND_COND,     0},
    '{18,  TYPE_TEMP_HUM, 0,            KIND_NONE,     0},
    '{19,  TYPE_TEMP_HUM, 32'h7FFF8000, KIND_TEMP_HUM, 1},
    '{17,  TYPE_FORMALD,  1000,         KIND_FORMALD,  1},
    '{17,  TYPE_FORMALD,  -1,           KIND_FORMALD,  0},
    '{19,  8'hFF,         0,            KIND_NONE,     0},
    '{300, TYPE_MOIST,    0,            KIND_MOIST,    1},
    '{20,  TYPE_MOIST,    0,            KIND_MOIST,    0}
  };

  sensor_advert_frame_parser uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_frame_byte(in_frame_byte),
    .in_final_byte(in_final_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_device_address(out_device_address),
    .out_measure_kind(out_measure_kind),
    .out_value_changed(out_value_changed),
    .out_plant_ready(out_plant_ready),
    .out_temperature_tenths(out_temperature_tenths),
    .out_humidity_tenths(out_humidity_tenths),
    .out_light_lux(out_light_lux),
    .out_moisture_pct(out_moisture_pct),
    .out_conductivity(out_conductivity),
    .out_battery_level(out_battery_level),
    .out_formaldehyde_tenths(out_formaldehyde_tenths)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit renew(inout int store, input int v);
    if (store == v) return 1'b0;
    store = v;
    return 1'b1;
  endfunction

  // Absorbs one word; returns 1 with the expected result when the word ends a frame.
  function automatic bit parse_advert_byte(input logic [7:0] b, input logic last,
                                           output advert_result_t r);
    int len;
    int lo;
    int hi;
    int lux;
    bit chg;
    r = '0;
    chg = 1'b0;
    len = pos_q + 1;
    if (pos_q >= 5 && pos_q <= 10 && !addr_known) addr_q[(pos_q - 5) * 8 +: 8] = b;
    if (pos_q == 12) type_q = b;
    if (pos_q >= 15 && pos_q <= 18) val_q[(pos_q - 15) * 8 +: 8] = b;
    if (!last) begin
      if (pos_q < 255) pos_q++;
      return 1'b0;
    end
    pos_q = 0;
    if (len >= 12) addr_known = 1'b1;
    if (len >= 16) begin
      lo = $signed(val_q[15:0]);
      hi = $signed(val_q[31:16]);
      case (type_q)
        TYPE_TEMP: if (len >= 17) begin
          r.kind = KIND_TEMP;
          if (lo > TEMP_LO && lo < TEMP_HI) chg |= renew(temp_st, lo);
        end
        TYPE_HUMID: if (len >= 17) begin
          r.kind = KIND_HUMID;
          if (lo >= 0 && lo <= HUMID_HI) chg |= renew(hum_st, lo);
        end
        TYPE_LIGHT: if (len >= 18) begin
          r.kind = KIND_LIGHT;
          lux = int'(val_q[23:0]);
          if (lux < int'(LIGHT_LIMIT)) chg |= renew(lux_st, lux);
        end
        TYPE_MOIST: if (len >= 17) begin
          r.kind = KIND_MOIST;
          if (lo >= 0 && lo <= MOIST_HI) chg |= renew(moist_st, lo);
        end
        TYPE_COND: if (len >= 17) begin
          r.kind = KIND_COND;
          if (lo >= 0 && lo < COND_LIMIT) chg |= renew(cond_st, lo);
        end
        TYPE_BATT: begin
          r.kind = KIND_BATT;
          chg |= renew(batt_st, $signed(val_q[7:0]));
        end
        TYPE_TEMP_HUM: if (len >= 19) begin
          r.kind = KIND_TEMP_HUM;
          chg |= renew(temp_st, lo);
          chg |= renew(hum_st, hi);
        end
        TYPE_FORMALD: if (len >= 17) begin
          r.kind = KIND_FORMALD;
          if (lo >= 0 && lo <= FORMALD_HI) chg |= renew(form_st, lo);
        end
        default: ;
      endcase
    end
    r.addr = addr_known ? addr_q : '0;
    r.chg = chg;
    r.rdy = moist_st > MOIST_UNKNOWN && cond_st > COND_UNKNOWN &&
            temp_st > TEMP_UNKNOWN && lux_st > LIGHT_UNKNOWN;
    r.temp = temp_st[15:0];
    r.hum = hum_st[15:0];
    r.lux = lux_st[18:0];
    r.moist = moist_st[7:0];
    r.cond = cond_st[15:0];
    r.batt = batt_st[7:0];
    r.form = form_st[10:0];
    return 1'b1;
  endfunction

  function automatic int pace_gap(input int mode);
    case (mode)
      0: return 0;
      1: return $urandom_range(0, 14);
      default: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 14) : 0;
    endcase
  endfunction

  function automatic logic [7:0] pick_code();
    logic [7:0] codes [0:7] = '{TYPE_TEMP, TYPE_HUMID, TYPE_LIGHT, TYPE_MOIST,
                                TYPE_COND, TYPE_BATT, TYPE_TEMP_HUM, TYPE_FORMALD};
    if ($urandom_range(0, 99) < 85) return codes[3'($urandom_range(0, 7))];
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [31:0] pick_value(input logic [31:0] prev);
    int edges [0:15] = '{-301, -300, -299, -1, 0, 1, 99, 100, 101, 999, 1000, 1001,
                         19999, 20000, 149999, 150000};
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return prev;
    if (r < 40) return edges[4'($urandom_range(0, 15))];
    if (r < 70) return int'($urandom_range(0, 2000)) - 500;
    if (r < 85) return $urandom_range(0, 160000);
    return $urandom();
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(16, 20);
    if (r < 85) return $urandom_range(1, 15);
    if (r < 98) return $urandom_range(21, 40);
    return $urandom_range(250, 300);
  endfunction

  // Offers one word, predicting at the edge where it is taken. Returns at a falling edge.
  task automatic send_byte(input logic [7:0] b, input logic last,
                           input int want_kind, input int want_chg);
    int gap;
    advert_result_t r;
    gap = pace_gap(sender_pace);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_frame_byte <= b;
    in_final_byte <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (parse_advert_byte(b, last, r)) begin
      if (want_kind != NO_TYPED) r.kind = want_kind[3:0];
      if (want_chg != NO_TYPED) r.chg = want_chg[0];
      pending_adverts = {pending_adverts, r};
    end
    @(negedge clk);
  endtask

  task automatic send_frame(input int len, input logic [7:0] code, input logic [31:0] val,
                            input int want_kind, input int want_chg);
    logic [7:0] b;
    if ($urandom_range(0, 7) == 0) sender_pace = $urandom_range(0, 2);
    for (int p = 0; p < len; p++) begin
      if (p == 12) b = code;
      else if (p >= 15 && p <= 18) b = val[(p - 15) * 8 +: 8];
      else b = 8'($urandom_range(0, 255));
      send_byte(b, p == len - 1, p == len - 1 ? want_kind : NO_TYPED,
                p == len - 1 ? want_chg : NO_TYPED);
    end
  endtask

  function automatic void check_field(input string name, input logic signed [63:0] want,
                                      input logic signed [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    advert_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_adverts.size() == 0) begin
        $error("result word arrived with no expectation waiting");
        errors++;
      end else begin
        want = pending_adverts.pop_front();
        check_field("device_address", want.addr, out_device_address);
        check_field("measure_kind", want.kind, out_measure_kind);
        check_field("value_changed", want.chg, out_value_changed);
        check_field("plant_ready", want.rdy, out_plant_ready);
        check_field("temperature_tenths", want.temp, out_temperature_tenths);
        check_field("humidity_tenths", want.hum, out_humidity_tenths);
        check_field("light_lux", want.lux, out_light_lux);
        check_field("moisture_pct", want.moist, out_moisture_pct);
        check_field("conductivity", want.cond, out_conductivity);
        check_field("battery_level", want.batt, out_battery_level);
        check_field("formaldehyde_tenths", want.form, out_formaldehyde_tenths);
      end
    end
  end

  // Result side: random back-pressure, plus one long hold so the parser backs up.
  initial begin : result_drain
    int gap;
    int taken;
    bit held;
    taken = 0;
    held = 1'b0;
    @(posedge rst_n);
    forever begin
      if (!held && taken == 40) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      gap = pace_gap(receiver_pace);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
      if ($urandom_range(0, 9) == 0) receiver_pace = $urandom_range(0, 2);
      @(negedge clk);
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    int sent;
    int len;
    logic [7:0] code;
    logic [31:0] val;
    val = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (directed_frames[i])
      send_frame(directed_frames[i].len, directed_frames[i].code, directed_frames[i].val,
                 directed_frames[i].want_kind, directed_frames[i].want_chg);
    sent = 0;
    while (sent < RANDOM_BYTES) begin
      len = pick_len();
      code = pick_code();
      val = pick_value(val);
      send_frame(len, code, val, NO_TYPED, NO_TYPED);
      sent += len;
    end
    in_valid <= 1'b0;
    while (pending_adverts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
